// ----- rtl/mee_pkg.sv -----
// shared constants for the midpoint ellipse generator
// no dependencies; compiled first
`default_nettype none

package mee_pkg;

   localparam int RADIUS_BITS_DEF = 10;
   localparam int COORD_BITS_DEF  = 11;
   localparam int PIX_BITS        = 13;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

endpackage : mee_pkg

`default_nettype wire

// ----- rtl/mee_if.sv -----
// request and response channel interfaces of the midpoint ellipse generator
// depends on mee_pkg
`default_nettype none

interface mee_req_if #(
   parameter int RADIUS_BITS = mee_pkg::RADIUS_BITS_DEF,
   parameter int COORD_BITS  = mee_pkg::COORD_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic                   mode;
   logic [RADIUS_BITS-1:0] radius_x;
   logic [RADIUS_BITS-1:0] radius_y;
   logic [COORD_BITS-1:0]  center_x;
   logic [COORD_BITS-1:0]  center_y;

   modport source (output valid, mode, radius_x, radius_y, center_x, center_y,
                   input ready);
   modport sink   (input valid, mode, radius_x, radius_y, center_x, center_y,
                   output ready);
endinterface : mee_req_if

interface mee_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [mee_pkg::PIX_BITS-1:0] pixel_x;
   logic signed [mee_pkg::PIX_BITS-1:0] pixel_y;
   logic                                last_point;
   logic                                final_step;

   modport source (output valid, pixel_x, pixel_y, last_point, final_step,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, last_point, final_step,
                   output ready);
endinterface : mee_rsp_if

`default_nettype wire

// ----- rtl/mee_mul.sv -----
// shared unsigned multiplier with a registered product
// no package dependencies
`default_nettype none

module mee_mul #(
   parameter int OP_W = 24
) (
   input  wire logic              clock,
   input  wire logic [OP_W-1:0]   op_a,
   input  wire logic [OP_W-1:0]   op_b,
   output logic      [2*OP_W-1:0] product
);

   logic [2*OP_W-1:0] product_ff;
   logic [2*OP_W-1:0] product_in;

   assign product_in = op_a * op_b;
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule : mee_mul

`default_nettype wire

// ----- rtl/midpoint_ellipse_generator.sv -----
// Midpoint ellipse rasteriser. A start request (mode 0) latches both radii and the centre and
// sets up the region-one decision term; it gives no response and also runs the region-two
// setup when a zero radius sends it straight into region two. Each step request (mode 1)
// gives the four symmetric points of the current position, the fourth marked last_point, all
// four marked final_step on the step that ends the ellipse. A region-one step runs two update
// states, a region check and a finish state before its four points, with the region-two setup
// after the check on the step that crosses into region two; a region-two step skips the check,
// and a step while idle is dropped. All squares and the region-two setup products go through
// one registered multiplier. Decision values are exact, scaled by four.
// depends on mee_pkg, mee_if, mee_mul
`default_nettype none

module midpoint_ellipse_generator #(
   parameter int RADIUS_BITS = mee_pkg::RADIUS_BITS_DEF,
   parameter int COORD_BITS  = mee_pkg::COORD_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   mee_req_if.sink  req,
   mee_rsp_if.source rsp
);

   import mee_pkg::*;

   localparam int RB = RADIUS_BITS;
   localparam int CB = COORD_BITS;
   localparam int XW = RB + 2;           // position x, unsigned
   localparam int YW = RB + 2;           // position y, signed
   localparam int QW = 2 * RB;           // radius squared
   localparam int MA = 2 * RB + 4;       // multiplier operand
   localparam int DW = 2 * MA;           // decision and product
   localparam int SW = 3 * RB + 4;       // slopes, signed
   localparam int EW = PIX_BITS + CB + XW;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RX2, ST_RY2, ST_RXRY, ST_INIT, ST_CHECK,
      ST_R2A, ST_R2B, ST_R2C, ST_R2D, ST_R2E, ST_R2F,
      ST_S1A, ST_S1B, ST_S2A, ST_S2B, ST_FIN, ST_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [RB-1:0]         rx_ff, rx_in, ry_ff, ry_in;
   logic [CB-1:0]         cx_ff, cx_in, cy_ff, cy_in;
   logic [QW-1:0]         rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic [XW-1:0]         x_ff, x_in, ox_ff, ox_in;
   logic signed [YW-1:0]  y_ff, y_in, oy_ff, oy_in;
   logic signed [SW-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic signed [DW-1:0]  dec_ff, dec_in;
   logic                  region2_ff, region2_in;
   logic                  active_ff, active_in;
   logic                  step_ff, step_in;
   logic                  flag_ff, flag_in;
   logic                  fin_ff, fin_in;
   logic [1:0]            cnt_ff, cnt_in;

   logic [MA-1:0]         mul_a, mul_b;
   logic [DW-1:0]         product;
   logic signed [DW-1:0]  prod_d, rx2_d, ry2_d, dx_d, dy_d;
   logic signed [SW-1:0]  two_rx2, two_ry2;
   logic signed [YW:0]    ty;
   logic [MA-1:0]         tx_abs, ty_abs;
   logic                  dec_neg, dec_pos;
   logic [EW-1:0]         ext_cx, ext_cy, ext_x, ext_y, sum_x, sum_y;

   mee_mul #(.OP_W(MA)) u_mul (
      .clock  (clock),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .product(product)
   );

   assign prod_d  = product;
   assign rx2_d   = DW'(rx2_ff);
   assign ry2_d   = DW'(ry2_ff);
   assign dx_d    = DW'(dx_ff);
   assign dy_d    = DW'(dy_ff);
   assign two_rx2 = SW'({rx2_ff, 1'b0});
   assign two_ry2 = SW'({ry2_ff, 1'b0});
   assign ty      = YW'(y_ff) - (YW+1)'(1);
   assign ty_abs  = ty[YW] ? MA'(-ty) : MA'(ty);
   assign tx_abs  = MA'({x_ff, 1'b1});
   assign dec_neg = dec_ff[DW-1];
   assign dec_pos = !dec_ff[DW-1] && (dec_ff != '0);

   // multiplier operands; the registered product shows up in the next state
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_RX2:  begin mul_a = MA'(rx_ff);  mul_b = MA'(rx_ff); end
         ST_RY2:  begin mul_a = MA'(ry_ff);  mul_b = MA'(ry_ff); end
         ST_RXRY: begin mul_a = MA'(rx2_ff); mul_b = MA'(ry_ff); end
         ST_R2A:  begin mul_a = tx_abs;      mul_b = tx_abs; end
         ST_R2B:  begin mul_a = MA'(ry2_ff); mul_b = product[MA-1:0]; end
         ST_R2C:  begin mul_a = ty_abs;      mul_b = ty_abs; end
         ST_R2D:  begin mul_a = MA'(rx2_ff); mul_b = product[MA-1:0]; end
         ST_R2E:  begin mul_a = MA'(rx2_ff); mul_b = MA'(ry2_ff); end
         default: begin mul_a = '0;          mul_b = '0; end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      rx_in      = rx_ff;
      ry_in      = ry_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      rx2_in     = rx2_ff;
      ry2_in     = ry2_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      ox_in      = ox_ff;
      oy_in      = oy_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      dec_in     = dec_ff;
      region2_in = region2_ff;
      active_in  = active_ff;
      step_in    = step_ff;
      flag_in    = flag_ff;
      fin_in     = fin_ff;
      cnt_in     = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (req.mode == MODE_START) begin
                  rx_in    = req.radius_x;
                  ry_in    = req.radius_y;
                  cx_in    = req.center_x;
                  cy_in    = req.center_y;
                  step_in  = 1'b0;
                  state_in = ST_RX2;
               end else if (active_ff) begin
                  ox_in    = x_ff;
                  oy_in    = y_ff;
                  step_in  = 1'b1;
                  state_in = region2_ff ? ST_S2A : ST_S1A;
               end
            end
         end
         ST_RX2: begin
            state_in = ST_RY2;
         end
         ST_RY2: begin
            rx2_in   = product[QW-1:0];
            state_in = ST_RXRY;
         end
         ST_RXRY: begin
            ry2_in   = product[QW-1:0];
            dec_in   = (prod_d <<< 2) + rx2_d;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            dy_in      = SW'({product[SW-2:0], 1'b0});
            dec_in     = dec_ff - (prod_d <<< 2);
            dx_in      = '0;
            x_in       = '0;
            y_in       = YW'(ry_ff);
            region2_in = 1'b0;
            active_in  = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            if (!region2_ff && !(dx_ff < dy_ff)) begin
               state_in = ST_R2A;
            end else begin
               state_in = step_ff ? ST_FIN : ST_IDLE;
            end
         end
         ST_R2A: begin
            state_in = ST_R2B;
         end
         ST_R2B: begin
            state_in = ST_R2C;
         end
         ST_R2C: begin
            dec_in   = prod_d;
            state_in = ST_R2D;
         end
         ST_R2D: begin
            state_in = ST_R2E;
         end
         ST_R2E: begin
            dec_in   = dec_ff + (prod_d <<< 2);
            state_in = ST_R2F;
         end
         ST_R2F: begin
            dec_in     = dec_ff - (prod_d <<< 2);
            region2_in = 1'b1;
            state_in   = step_ff ? ST_FIN : ST_IDLE;
         end
         // region one: flag marks a horizontal move only
         ST_S1A: begin
            flag_in = dec_neg;
            dx_in   = dx_ff + two_ry2;
            x_in    = x_ff + XW'(1);
            if (!dec_neg) begin
               y_in  = y_ff - YW'(1);
               dy_in = dy_ff - two_rx2;
            end
            state_in = ST_S1B;
         end
         ST_S1B: begin
            dec_in   = dec_ff + (dx_d <<< 2) + (ry2_d <<< 2)
                       - (flag_ff ? DW'(0) : (dy_d <<< 2));
            state_in = ST_CHECK;
         end
         // region two: flag marks a vertical move only
         ST_S2A: begin
            flag_in = dec_pos;
            y_in    = y_ff - YW'(1);
            dy_in   = dy_ff - two_rx2;
            if (!dec_pos) begin
               x_in  = x_ff + XW'(1);
               dx_in = dx_ff + two_ry2;
            end
            state_in = ST_S2B;
         end
         ST_S2B: begin
            dec_in   = dec_ff + (rx2_d <<< 2) - (dy_d <<< 2)
                       + (flag_ff ? DW'(0) : (dx_d <<< 2));
            state_in = ST_FIN;
         end
         ST_FIN: begin
            active_in = !(region2_ff && y_ff[YW-1]);
            fin_in    = region2_ff && y_ff[YW-1];
            cnt_in    = '0;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp.ready) begin
               cnt_in = cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         active_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
      end
      rx_ff      <= rx_in;
      ry_ff      <= ry_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      rx2_ff     <= rx2_in;
      ry2_ff     <= ry2_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      ox_ff      <= ox_in;
      oy_ff      <= oy_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      dec_ff     <= dec_in;
      region2_ff <= region2_in;
      step_ff    <= step_in;
      flag_ff    <= flag_in;
      fin_ff     <= fin_in;
   end

   // point order: bit 0 mirrors x, bit 1 mirrors y
   assign ext_cx = EW'(cx_ff);
   assign ext_cy = EW'(cy_ff);
   assign ext_x  = EW'(ox_ff);
   assign ext_y  = EW'(oy_ff);
   assign sum_x  = cnt_ff[0] ? (ext_cx - ext_x) : (ext_cx + ext_x);
   assign sum_y  = cnt_ff[1] ? (ext_cy - ext_y) : (ext_cy + ext_y);

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = (state_ff == ST_EMIT);
   assign rsp.pixel_x    = sum_x[PIX_BITS-1:0];
   assign rsp.pixel_y    = sum_y[PIX_BITS-1:0];
   assign rsp.last_point = (cnt_ff == 2'd3);
   assign rsp.final_step = fin_ff;

endmodule : midpoint_ellipse_generator

`default_nettype wire

// ----- rtl/mee_checker.sv -----
// port-level checks for the midpoint ellipse generator, bound to the top level
// depends on mee_pkg and midpoint_ellipse_generator
`default_nettype none

module mee_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic req_mode,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_last_point,
   input wire logic rsp_final_step
);

   import mee_pkg::*;

   // one request at a time: never taking a request while points are out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("request taken while points pending");

   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == MODE_START) |=> !rsp_valid)
      else $error("start request produced a point");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_point) |=> !rsp_valid)
      else $error("points continue after last point");

   a_final_same: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_point)
         |=> (rsp_valid && rsp_final_step == $past(rsp_final_step)))
      else $error("final flag or point count broken within a step");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_last_point)))
      else $error("stalled point not held");

endmodule : mee_checker

bind midpoint_ellipse_generator mee_checker u_mee_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .req_mode       (req.mode),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_last_point (rsp.last_point),
   .rsp_final_step (rsp.final_step)
);

`default_nettype wire
